// ===== hw/rtl/bitmap_set_engine_defines.svh =====
// Assertion shorthands shared by the RTL
`ifndef BITMAP_SET_ENGINE_DEFINES_SVH
`define BITMAP_SET_ENGINE_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define BSE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off during reset
`define BSE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/bse_pkg.sv =====
package bse_pkg;

    localparam int WORD_BITS    = 32;
    localparam int MAX_ELEMENTS = 1024;
    localparam int NWORDS       = (MAX_ELEMENTS + WORD_BITS - 1) / WORD_BITS;
    localparam int WADDR_W      = $clog2(NWORDS);
    localparam int BIT_W        = $clog2(WORD_BITS);
    localparam int COUNT_W      = 11;
    localparam int INDEX_W      = 10;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [COUNT_W-1:0] SIZE_CAP  = COUNT_W'(MAX_ELEMENTS);

    localparam logic [2:0] ACT_CLEAR  = 3'd0;
    localparam logic [2:0] ACT_ADD    = 3'd1;
    localparam logic [2:0] ACT_REMOVE = 3'd2;
    localparam logic [2:0] ACT_QUERY  = 3'd3;
    localparam logic [2:0] ACT_INVERT = 3'd4;
    localparam logic [2:0] ACT_LIST   = 3'd5;

    typedef logic [WORD_BITS-1:0] t_word;

    typedef struct packed {
        logic               rd_en;
        logic [WADDR_W-1:0] rd_addr;
        logic               wr_en;
        logic [WADDR_W-1:0] wr_addr;
        t_word              wr_data;
        logic               clear;
        logic               invert;
    } t_store_req;

    function automatic logic [BIT_W-1:0] lowest_bit(input t_word w);
        logic [BIT_W-1:0] pos;
        pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (w[i]) begin
                pos = BIT_W'(i);
            end
        end
        return pos;
    endfunction

endpackage

// ===== hw/rtl/bse_store.sv =====
module bse_store (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bse_pkg::t_store_req i_req,
    output bse_pkg::t_word      o_rd_word
);
    import bse_pkg::*;

    t_word              mem [NWORDS];
    t_word              r_rd_raw;
    logic               r_rd_ok;
    logic [NWORDS-1:0]  r_written;
    logic               r_inv;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_req.wr_addr] <= i_req.wr_data ^ {WORD_BITS{r_inv}};
        end
        if (i_req.rd_en) begin
            r_rd_raw <= mem[i_req.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
            r_inv     <= 1'b0;
            r_rd_ok   <= 1'b0;
        end else begin
            if (i_req.clear) begin
                r_written <= '0;
                r_inv     <= 1'b0;
            end else begin
                if (i_req.invert) begin
                    r_inv <= ~r_inv;
                end
                if (i_req.wr_en) begin
                    r_written[i_req.wr_addr] <= 1'b1;
                end
            end
            if (i_req.rd_en) begin
                r_rd_ok <= r_written[i_req.rd_addr];
            end
        end
    end

    // unwritten words read as empty; the invert flag applies to every word
    assign o_rd_word = (r_rd_ok ? r_rd_raw : '0) ^ {WORD_BITS{r_inv}};

endmodule

// ===== hw/rtl/bitmap_set_engine.sv =====
// Bitmap set engine: a set of element numbers below a universe size, with a member count.
// Input channel: i_in_valid / o_in_stall carrying i_action, i_index, i_word_select.
// Output channel: o_out_valid / i_out_stall carrying o_is_member, o_member_count,
// o_element, o_element_valid and o_last; a transfer happens when valid is high and stall low.
// Configuration: i_cfg_we writes i_cfg_data into the universe size, only while idle;
// the user must keep to this, as the block itself does not enforce it. Clear, add, remove,
// query, invert and the spare codes give one result, which the result register loads in
// S_EXEC once the output is free; no new item is taken until the engine is back in S_IDLE.
// List gives one result per member of the word below the size, ascending, one per cycle
// while the output is not stalled (a single result marked invalid when the word is empty).
// Each item makes one word read, then at most one write back. Clear and invert act on
// every word at once through per-word written flags and an invert flag. Reset (synchronous,
// active low) empties the set, zeroes the count and sets the size to 1024. While i_out_stall
// is high a valid result holds and the engine waits; o_in_stall is high while not idle.
`include "bitmap_set_engine_defines.svh"

module bitmap_set_engine (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bse_pkg::COUNT_W-1:0]   i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [2:0]                    i_action,
    input  logic [bse_pkg::INDEX_W-1:0]   i_index,
    input  logic [4:0]                    i_word_select,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_is_member,
    output logic [bse_pkg::COUNT_W-1:0]   o_member_count,
    output logic [bse_pkg::INDEX_W-1:0]   o_element,
    output logic                          o_element_valid,
    output logic                          o_last
);
    import bse_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LIST
    } t_state;

    t_state               r_state, n_state;
    logic [COUNT_W-1:0]   r_size;
    logic [COUNT_W-1:0]   r_count, n_count;
    logic [2:0]           r_action;
    logic [INDEX_W-1:0]   r_index;
    logic [WADDR_W-1:0]   r_wsel;
    t_word                r_scan, n_scan;

    logic                 r_out_valid, n_out_valid;
    logic                 r_out_member, n_out_member;
    logic [COUNT_W-1:0]   r_out_count, n_out_count;
    logic [INDEX_W-1:0]   r_out_elem, n_out_elem;
    logic                 r_out_evalid, n_out_evalid;
    logic                 r_out_last, n_out_last;

    t_store_req           st_req;
    t_word                rd_word;
    logic                 in_accept;
    logic                 out_free;
    logic [COUNT_W-1:0]   eff_size;
    logic [BIT_W-1:0]     bit_pos;
    logic                 bit_set;
    logic                 in_range;
    t_word                range_mask;
    t_word                scan_rest;
    logic [BIT_W-1:0]     scan_pos;

    bse_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (st_req),
        .o_rd_word (rd_word)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    assign eff_size = (r_size > SIZE_CAP) ? SIZE_CAP : r_size;
    assign bit_pos  = r_index[BIT_W-1:0];
    assign bit_set  = rd_word[bit_pos];
    assign in_range = {1'b0, r_index} < eff_size;

    always_comb begin
        if (eff_size[COUNT_W-1:BIT_W] > (COUNT_W-BIT_W)'(r_wsel)) begin
            range_mask = '1;
        end else if (eff_size[COUNT_W-1:BIT_W] == (COUNT_W-BIT_W)'(r_wsel)) begin
            range_mask = (t_word'(1) << eff_size[BIT_W-1:0]) - t_word'(1);
        end else begin
            range_mask = '0;
        end
    end

    assign scan_pos  = lowest_bit(r_scan);
    assign scan_rest = r_scan & (r_scan - t_word'(1));

    always_comb begin
        st_req         = '0;
        st_req.rd_en   = in_accept;
        st_req.rd_addr = (i_action == ACT_LIST) ? WADDR_W'(i_word_select)
                                                : i_index[BIT_W +: WADDR_W];
        st_req.wr_addr = r_index[BIT_W +: WADDR_W];
        st_req.wr_data = rd_word;

        n_state      = r_state;
        n_count      = r_count;
        n_scan       = r_scan;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_member = r_out_member;
        n_out_count  = r_out_count;
        n_out_elem   = r_out_elem;
        n_out_evalid = r_out_evalid;
        n_out_last   = r_out_last;

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    n_state      = S_IDLE;
                    n_out_valid  = 1'b1;
                    n_out_member = 1'b0;
                    n_out_elem   = '0;
                    n_out_evalid = 1'b0;
                    n_out_last   = 1'b1;
                    case (r_action)
                        ACT_CLEAR: begin
                            st_req.clear = 1'b1;
                            n_count      = '0;
                        end
                        ACT_ADD: begin
                            if (in_range && !bit_set) begin
                                st_req.wr_en   = 1'b1;
                                st_req.wr_data = rd_word | (t_word'(1) << bit_pos);
                                if (r_count != COUNT_MAX) begin
                                    n_count = r_count + 1'b1;
                                end
                            end
                        end
                        ACT_REMOVE: begin
                            if (in_range && bit_set && r_count != '0) begin
                                st_req.wr_en   = 1'b1;
                                st_req.wr_data = rd_word & ~(t_word'(1) << bit_pos);
                                n_count        = r_count - 1'b1;
                            end
                        end
                        ACT_QUERY: begin
                            n_out_member = in_range && bit_set;
                        end
                        ACT_INVERT: begin
                            st_req.invert = 1'b1;
                            n_count = (r_count <= eff_size) ? eff_size - r_count : '0;
                        end
                        ACT_LIST: begin
                            n_scan = rd_word & range_mask;
                            if (n_scan != '0) begin
                                n_state     = S_LIST;
                                n_out_valid = 1'b0;
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_out_count = n_count;
                end
            end
            S_LIST: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_member = 1'b0;
                    n_out_count  = r_count;
                    n_out_elem   = {r_wsel, scan_pos};
                    n_out_evalid = 1'b1;
                    n_out_last   = (scan_rest == '0);
                    n_scan       = scan_rest;
                    if (scan_rest == '0) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_size      <= SIZE_CAP;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_size <= i_cfg_data;
            end
        end
        if (in_accept) begin
            r_action <= i_action;
            r_index  <= i_index;
            r_wsel   <= WADDR_W'(i_word_select);
        end
        r_scan       <= n_scan;
        r_out_member <= n_out_member;
        r_out_count  <= n_out_count;
        r_out_elem   <= n_out_elem;
        r_out_evalid <= n_out_evalid;
        r_out_last   <= n_out_last;
    end

    assign o_out_valid     = r_out_valid;
    assign o_is_member     = r_out_member;
    assign o_member_count  = r_out_count;
    assign o_element       = r_out_elem;
    assign o_element_valid = r_out_evalid;
    assign o_last          = r_out_last;

    `BSE_ASSERT_NEXT(a_accept_to_exec, in_accept, r_state == S_EXEC, "accept did not start work")
    `BSE_ASSERT_NOW(a_list_nonempty, r_state == S_LIST, r_scan != '0, "list scan word is empty")
    `BSE_ASSERT_NOW(a_more_only_in_list, r_out_valid && !r_out_last, r_state == S_LIST,
                    "non-final result outside a list walk")
    `BSE_ASSERT_NOW(a_write_alone, st_req.wr_en, !st_req.clear && !st_req.invert && !st_req.rd_en,
                    "word write overlaps clear, invert or read")

endmodule

// ===== dv/tb_bitmap_set_engine.sv =====
module tb_bitmap_set_engine;
    import bse_pkg::*;

    localparam logic [2:0] ACT_RESERVED_6 = 3'd6;
    localparam logic [2:0] ACT_RESERVED_7 = 3'd7;
    localparam int IDLE_PCT      = 14;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 40;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_PHASES = 7;
    localparam int PHASE_ITEMS   = 26;
    localparam int OVERRUN_ADDS  = 16;

    typedef struct packed {
        logic               is_member;
        logic [COUNT_W-1:0] member_count;
        logic [INDEX_W-1:0] element;
        logic               element_valid;
        logic               last;
    } t_set_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [COUNT_W-1:0]   i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [2:0]           i_action = ACT_CLEAR;
    logic [INDEX_W-1:0]   i_index = '0;
    logic [4:0]           i_word_select = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic                 o_is_member;
    logic [COUNT_W-1:0]   o_member_count;
    logic [INDEX_W-1:0]   o_element;
    logic                 o_element_valid;
    logic                 o_last;

    logic [WORD_BITS-1:0] set_words [0:NWORDS-1];
    logic [COUNT_W-1:0]   set_count;
    logic [COUNT_W-1:0]   univ_size;
    t_set_result          pending_results [$];

    bit quiet = 1'b0;
    int mismatch_count = 0;
    int items_sent = 0;
    int results_checked = 0;
    int sizes_tried = 0;
    int cycle_count = 0;

    bitmap_set_engine dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_action        (i_action),
        .i_index         (i_index),
        .i_word_select   (i_word_select),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_is_member     (o_is_member),
        .o_member_count  (o_member_count),
        .o_element       (o_element),
        .o_element_valid (o_element_valid),
        .o_last          (o_last)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || quiet) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(99) < IDLE_PCT);
        end
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    endtask

    always @(posedge i_clk) begin
        t_set_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result transfer with nothing expected");
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (o_is_member !== want.is_member)
                    report_mismatch($sformatf("is_member %b, expected %b",
                                              o_is_member, want.is_member));
                if (o_member_count !== want.member_count)
                    report_mismatch($sformatf("member_count %0d, expected %0d",
                                              o_member_count, want.member_count));
                if (o_element !== want.element)
                    report_mismatch($sformatf("element %0d, expected %0d",
                                              o_element, want.element));
                if (o_element_valid !== want.element_valid)
                    report_mismatch($sformatf("element_valid %b, expected %b",
                                              o_element_valid, want.element_valid));
                if (o_last !== want.last)
                    report_mismatch($sformatf("last %b, expected %b", o_last, want.last));
            end
        end
    end

    task automatic push_expected(input logic mem, input logic [INDEX_W-1:0] elem,
                                 input logic elem_valid, input logic fin);
        t_set_result r;
        r.is_member     = mem;
        r.member_count  = set_count;
        r.element       = elem;
        r.element_valid = elem_valid;
        r.last          = fin;
        pending_results.push_back(r);
    endtask

    task automatic apply_action(input logic [2:0] act, input logic [INDEX_W-1:0] idx,
                                input logic [4:0] wsel);
        int  eff;
        int  w;
        int  b;
        int  elem;
        int  hits;
        int  emitted;
        bit  in_range;
        logic mem;
        eff      = (univ_size < SIZE_CAP) ? int'(univ_size) : MAX_ELEMENTS;
        w        = int'(idx) / WORD_BITS;
        b        = int'(idx) % WORD_BITS;
        in_range = (int'(idx) < eff) && (w < NWORDS);
        mem      = 1'b0;
        case (act)
            ACT_CLEAR: begin
                for (int i = 0; i < NWORDS; i++) set_words[i] = '0;
                set_count = '0;
            end
            ACT_ADD: begin
                if (in_range && !set_words[w][b]) begin
                    set_words[w][b] = 1'b1;
                    if (set_count != COUNT_MAX) set_count++;
                end
            end
            ACT_REMOVE: begin
                if (in_range && set_count != 0 && set_words[w][b]) begin
                    set_words[w][b] = 1'b0;
                    set_count--;
                end
            end
            ACT_QUERY: begin
                if (in_range) mem = set_words[w][b];
            end
            ACT_INVERT: begin
                for (int i = 0; i < NWORDS; i++) set_words[i] = ~set_words[i];
                set_count = (int'(set_count) <= eff) ? COUNT_W'(eff - int'(set_count)) : '0;
            end
            ACT_LIST: begin
                hits = 0;
                for (int i = 0; i < WORD_BITS; i++) begin
                    elem = int'(wsel) * WORD_BITS + i;
                    if (int'(wsel) < NWORDS && elem < eff && set_words[wsel][i]) hits++;
                end
                if (hits == 0) begin
                    push_expected(1'b0, '0, 1'b0, 1'b1);
                end else begin
                    emitted = 0;
                    for (int i = 0; i < WORD_BITS; i++) begin
                        elem = int'(wsel) * WORD_BITS + i;
                        if (elem < eff && set_words[wsel][i]) begin
                            emitted++;
                            push_expected(1'b0, INDEX_W'(elem), 1'b1, emitted == hits);
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        if (act != ACT_LIST) push_expected(mem, '0, 1'b0, 1'b1);
    endtask

    task automatic send_item(input logic [2:0] act, input logic [INDEX_W-1:0] idx,
                             input logic [4:0] wsel);
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_action      <= act;
        i_index       <= idx;
        i_word_select <= wsel;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        apply_action(act, idx, wsel);
        items_sent++;
    endtask

    // hold the sender until every expected transfer has arrived
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_size(input logic [COUNT_W-1:0] value);
        drain_results();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we  <= 1'b0;
        univ_size = value;
        sizes_tried++;
    endtask

    function automatic logic [2:0] pick_action();
        int r;
        r = $urandom_range(99);
        if (r < 30) return ACT_ADD;
        if (r < 48) return ACT_REMOVE;
        if (r < 70) return ACT_QUERY;
        if (r < 84) return ACT_LIST;
        if (r < 89) return ACT_INVERT;
        if (r < 93) return ACT_CLEAR;
        if (r < 96) return ACT_RESERVED_6;
        return ACT_RESERVED_7;
    endfunction

    function automatic logic [INDEX_W-1:0] pick_index();
        int eff;
        int r;
        int lo;
        int hi;
        eff = (univ_size < SIZE_CAP) ? int'(univ_size) : MAX_ELEMENTS;
        r   = $urandom_range(99);
        lo  = (eff > 2) ? eff - 2 : 0;
        hi  = (eff + 1 > MAX_ELEMENTS - 1) ? MAX_ELEMENTS - 1 : eff + 1;
        if (r < 55) return INDEX_W'($urandom_range(3 * WORD_BITS - 1));
        if (r < 75) return INDEX_W'($urandom_range(hi, lo));
        return INDEX_W'($urandom_range(MAX_ELEMENTS - 1));
    endfunction

    task automatic test_basic_actions();
        send_item(ACT_CLEAR, '0, '0);
        send_item(ACT_ADD, 10'd0, '0);
        send_item(ACT_ADD, 10'd1023, '0);
        send_item(ACT_ADD, 10'd1023, '0);
        send_item(ACT_ADD, 10'd33, '0);
        send_item(ACT_ADD, 10'd63, '0);
        send_item(ACT_QUERY, 10'd1023, '0);
        send_item(ACT_QUERY, 10'd512, '0);
        send_item(ACT_LIST, '0, 5'd1);
        send_item(ACT_LIST, '0, 5'd31);
        send_item(ACT_LIST, '0, 5'd5);
        send_item(ACT_REMOVE, 10'd33, '0);
        send_item(ACT_REMOVE, 10'd33, '0);
        send_item(ACT_RESERVED_6, 10'd1023, 5'd31);
        send_item(ACT_RESERVED_7, '0, '0);
        send_item(ACT_INVERT, '0, '0);
        send_item(ACT_LIST, '0, 5'd2);
        send_item(ACT_LIST, '0, 5'd0);
        send_item(ACT_QUERY, 10'd0, '0);
        send_item(ACT_QUERY, 10'd1022, '0);
        drain_results();
    endtask

    task automatic test_size_edges();
        send_item(ACT_CLEAR, '0, '0);
        write_size(11'd0);
        send_item(ACT_ADD, 10'd5, '0);
        send_item(ACT_QUERY, 10'd5, '0);
        send_item(ACT_INVERT, '0, '0);
        send_item(ACT_LIST, '0, 5'd0);
        write_size(11'd40);
        send_item(ACT_QUERY, 10'd5, '0);
        send_item(ACT_REMOVE, 10'd5, '0);
        send_item(ACT_QUERY, 10'd5, '0);
        send_item(ACT_LIST, '0, 5'd1);
        send_item(ACT_QUERY, 10'd40, '0);
        send_item(ACT_ADD, 10'd41, '0);
        send_item(ACT_CLEAR, '0, '0);
        write_size(11'd1024);
        send_item(ACT_ADD, 10'd100, '0);
        send_item(ACT_ADD, 10'd200, '0);
        send_item(ACT_ADD, 10'd300, '0);
        write_size(11'd2);
        send_item(ACT_INVERT, '0, '0);
        send_item(ACT_LIST, '0, 5'd0);
        write_size(11'd2047);
        send_item(ACT_ADD, 10'd1023, '0);
        send_item(ACT_QUERY, 10'd1023, '0);
        send_item(ACT_LIST, '0, 5'd31);
        drain_results();
    endtask

    // drive the count past the number of set bits, then clamp it through invert
    task automatic test_count_overrun();
        quiet = 1'b1;
        write_size(11'd1024);
        send_item(ACT_CLEAR, '0, '0);
        write_size(11'd0);
        send_item(ACT_INVERT, '0, '0);
        write_size(11'd1024);
        send_item(ACT_INVERT, '0, '0);
        for (int i = 0; i < OVERRUN_ADDS; i++) send_item(ACT_ADD, INDEX_W'(i * 61), '0);
        send_item(ACT_ADD, 10'd0, '0);
        for (int i = 0; i < 4; i++) send_item(ACT_REMOVE, INDEX_W'(i * 61), '0);
        send_item(ACT_LIST, '0, 5'd7);
        write_size(11'd2);
        send_item(ACT_INVERT, '0, '0);
        send_item(ACT_QUERY, 10'd1, '0);
        write_size(11'd1024);
        send_item(ACT_CLEAR, '0, '0);
        drain_results();
        quiet = 1'b0;
    endtask

    task automatic test_random_traffic();
        logic [COUNT_W-1:0] size_plan [0:RANDOM_PHASES-1];
        logic [4:0]         wsel;
        size_plan[0] = 11'd1024;
        size_plan[1] = 11'd37;
        size_plan[2] = 11'd2047;
        size_plan[3] = 11'd700;
        size_plan[4] = 11'd1;
        size_plan[5] = 11'd32;
        size_plan[6] = COUNT_W'($urandom_range(2047));
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_size(size_plan[p]);
            quiet = (p == 3);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                wsel = ($urandom_range(99) < 70) ? 5'($urandom_range(3))
                                                 : 5'($urandom_range(31));
                send_item(pick_action(), pick_index(), wsel);
                if ($urandom_range(39) == 0) drain_results();
            end
            quiet = 1'b0;
        end
        drain_results();
    endtask

    initial begin
        for (int i = 0; i < NWORDS; i++) set_words[i] = '0;
        set_count = '0;
        univ_size = SIZE_CAP;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_basic_actions();
        test_size_edges();
        test_count_overrun();
        test_random_traffic();
        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Sent %0d actions, checked %0d result transfers, %0d size writes",
                 items_sent, results_checked, sizes_tried);
        $display("Covered all actions, spare codes, size extremes and a count above the set bits");
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
